// ----- rtl/core/hof_pkg.sv -----
`timescale 1ns / 1ps
// shared constants for the 3x3 outlier filter
// no dependencies

package hof_pkg;

  // window geometry
  localparam int ROWS = 3;
  localparam int COLS = 3;

  // scale register: unsigned q4.4
  localparam int SCALE_WIDTH = 8;
  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 8'd72;
  localparam int Q_SHIFT = 4;

endpackage

// ----- rtl/core/hof_sort3_lane.sv -----
`timescale 1ns / 1ps
// one row lane: sorts three values into max, middle and min
// depends on hof_pkg

module hof_sort3_lane import hof_pkg::*; #(
  parameter int W = 8
) (
  input  logic [W-1:0] row [COLS],
  output logic [W-1:0] hi,
  output logic [W-1:0] mid,
  output logic [W-1:0] lo
);

  logic [W-1:0] ab_min;
  logic [W-1:0] ab_max;
  logic [W-1:0] mx_c_min;

  always_comb begin
    ab_min   = (row[0] < row[1]) ? row[0] : row[1];
    ab_max   = (row[0] > row[1]) ? row[0] : row[1];
    hi       = (ab_max > row[2]) ? ab_max : row[2];
    lo       = (ab_min < row[2]) ? ab_min : row[2];
    mx_c_min = (ab_max < row[2]) ? ab_max : row[2];
    mid      = (ab_min > mx_c_min) ? ab_min : mx_c_min;
  end

endmodule

// ----- rtl/core/hof_median_merge.sv -----
`timescale 1ns / 1ps
// merge stage of the nine-input median network
// depends on hof_pkg

module hof_median_merge import hof_pkg::*; #(
  parameter int W = 8
) (
  input  logic [W-1:0] hi  [ROWS],
  input  logic [W-1:0] mid [ROWS],
  input  logic [W-1:0] lo  [ROWS],
  output logic [W-1:0] median
);

  logic [W-1:0] min_hi;
  logic [W-1:0] max_lo;
  logic [W-1:0] med_mid;
  logic [W-1:0] t_min;
  logic [W-1:0] t_max;
  logic [W-1:0] t_mc;
  logic [W-1:0] u_min;
  logic [W-1:0] u_max;
  logic [W-1:0] u_mc;

  always_comb begin
    min_hi = (hi[0] < hi[1]) ? hi[0] : hi[1];
    min_hi = (min_hi < hi[2]) ? min_hi : hi[2];
    max_lo = (lo[0] > lo[1]) ? lo[0] : lo[1];
    max_lo = (max_lo > lo[2]) ? max_lo : lo[2];

    // median of row middles
    t_min   = (mid[0] < mid[1]) ? mid[0] : mid[1];
    t_max   = (mid[0] > mid[1]) ? mid[0] : mid[1];
    t_mc    = (t_max < mid[2]) ? t_max : mid[2];
    med_mid = (t_min > t_mc) ? t_min : t_mc;

    // median of the three candidates
    u_min  = (min_hi < med_mid) ? min_hi : med_mid;
    u_max  = (min_hi > med_mid) ? min_hi : med_mid;
    u_mc   = (u_max < max_lo) ? u_max : max_lo;
    median = (u_min > u_mc) ? u_min : u_mc;
  end

endmodule

// ----- rtl/core/hampel_outlier_3x3.sv -----
`timescale 1ns / 1ps
// top level of the 3x3 hampel outlier filter: six-stage pipeline
// depends on hof_pkg, hof_sort3_lane, hof_median_merge

// Takes one 3x3 window word per clock (start while busy is low; busy never
// rises) and returns one filtered pixel per window, strobed by done for a
// single cycle when the result leaves the last pipeline stage. The receiver
// cannot stall: results are presented once and must be captured then. Three
// row lanes sort the window, a merge stage forms the median, nine
// absolute-difference lanes feed a second set of row lanes and merge for the
// mad, then an 8 x PIXEL_WIDTH multiply sets the threshold for the final
// keep/replace pick. Throughput is one window per cycle, set by the fully
// pipelined lanes. threshold_scale (unsigned q4.4, reset 4.5) is written over
// the cfg channel, which is always ready; write it only while no window is in
// flight.

module hampel_outlier_3x3 import hof_pkg::*; #(
  parameter int PIXEL_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // window input
  input  logic                   start,
  output logic                   busy,
  input  logic [PIXEL_WIDTH-1:0] pixel_r0c0,
  input  logic [PIXEL_WIDTH-1:0] pixel_r0c1,
  input  logic [PIXEL_WIDTH-1:0] pixel_r0c2,
  input  logic [PIXEL_WIDTH-1:0] pixel_r1c0,
  input  logic [PIXEL_WIDTH-1:0] pixel_r1c1,
  input  logic [PIXEL_WIDTH-1:0] pixel_r1c2,
  input  logic [PIXEL_WIDTH-1:0] pixel_r2c0,
  input  logic [PIXEL_WIDTH-1:0] pixel_r2c1,
  input  logic [PIXEL_WIDTH-1:0] pixel_r2c2,
  input  logic [PIXEL_WIDTH-1:0] center_pixel,
  // result
  output logic                   done,
  output logic [PIXEL_WIDTH-1:0] filtered_pixel,
  // scale register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SCALE_WIDTH-1:0] cfg_wdata
);

  localparam int W      = PIXEL_WIDTH;
  localparam int PROD_W = SCALE_WIDTH + PIXEL_WIDTH;

  // pipeline never stalls, so every start is taken
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = start & ~busy;

  // scale register
  logic [SCALE_WIDTH-1:0] threshold_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold_scale <= cfg_wdata;
    end
  end

  // stage valid chain
  logic [5:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], accept};
    end
  end

  // window as rows
  logic [W-1:0] win_in [ROWS][COLS];

  always_comb begin
    win_in[0][0] = pixel_r0c0;
    win_in[0][1] = pixel_r0c1;
    win_in[0][2] = pixel_r0c2;
    win_in[1][0] = pixel_r1c0;
    win_in[1][1] = pixel_r1c1;
    win_in[1][2] = pixel_r1c2;
    win_in[2][0] = pixel_r2c0;
    win_in[2][1] = pixel_r2c1;
    win_in[2][2] = pixel_r2c2;
  end

  // stage 1: row sort lanes on the window
  logic [W-1:0] hi_c  [ROWS];
  logic [W-1:0] mid_c [ROWS];
  logic [W-1:0] lo_c  [ROWS];
  logic [W-1:0] hi1   [ROWS];
  logic [W-1:0] mid1  [ROWS];
  logic [W-1:0] lo1   [ROWS];
  logic [W-1:0] win1  [ROWS][COLS];
  logic [W-1:0] center1;

  for (genvar r = 0; r < ROWS; r++) begin : g_row_a
    hof_sort3_lane #(.W(W)) u_lane (
      .row (win_in[r]),
      .hi  (hi_c[r]),
      .mid (mid_c[r]),
      .lo  (lo_c[r])
    );
  end

  always_ff @(posedge clk) begin
    hi1     <= hi_c;
    mid1    <= mid_c;
    lo1     <= lo_c;
    win1    <= win_in;
    center1 <= center_pixel;
  end

  // stage 2: merge for the window median
  logic [W-1:0] med_c;
  logic [W-1:0] med2;
  logic [W-1:0] win2 [ROWS][COLS];
  logic [W-1:0] center2;

  hof_median_merge #(.W(W)) u_merge_med (
    .hi     (hi1),
    .mid    (mid1),
    .lo     (lo1),
    .median (med_c)
  );

  always_ff @(posedge clk) begin
    med2    <= med_c;
    win2    <= win1;
    center2 <= center1;
  end

  // stage 3: absolute differences, then row sort lanes on them
  logic [W-1:0] diff   [ROWS][COLS];
  logic [W-1:0] dhi_c  [ROWS];
  logic [W-1:0] dmid_c [ROWS];
  logic [W-1:0] dlo_c  [ROWS];
  logic [W-1:0] dhi3   [ROWS];
  logic [W-1:0] dmid3  [ROWS];
  logic [W-1:0] dlo3   [ROWS];
  logic [W-1:0] med3;
  logic [W-1:0] center3;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        diff[r][c] = (win2[r][c] > med2) ? (win2[r][c] - med2) : (med2 - win2[r][c]);
      end
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row_b
    hof_sort3_lane #(.W(W)) u_lane (
      .row (diff[r]),
      .hi  (dhi_c[r]),
      .mid (dmid_c[r]),
      .lo  (dlo_c[r])
    );
  end

  always_ff @(posedge clk) begin
    dhi3    <= dhi_c;
    dmid3   <= dmid_c;
    dlo3    <= dlo_c;
    med3    <= med2;
    center3 <= center2;
  end

  // stage 4: merge for the mad, center distance
  logic [W-1:0] mad_c;
  logic [W-1:0] mad4;
  logic [W-1:0] dc4;
  logic [W-1:0] med4;
  logic [W-1:0] center4;

  hof_median_merge #(.W(W)) u_merge_mad (
    .hi     (dhi3),
    .mid    (dmid3),
    .lo     (dlo3),
    .median (mad_c)
  );

  always_ff @(posedge clk) begin
    mad4    <= mad_c;
    dc4     <= (center3 > med3) ? (center3 - med3) : (med3 - center3);
    med4    <= med3;
    center4 <= center3;
  end

  // stage 5: threshold = scale * mad and distance, both in q12.4
  logic [PROD_W-1:0] thresh5;
  logic [PROD_W-1:0] dist5;
  logic [W-1:0]      med5;
  logic [W-1:0]      center5;

  always_ff @(posedge clk) begin
    thresh5 <= PROD_W'(threshold_scale) * PROD_W'(mad4);
    dist5   <= PROD_W'(dc4) << Q_SHIFT;
    med5    <= med4;
    center5 <= center4;
  end

  // stage 6: keep the center if inside the band, else the median
  always_ff @(posedge clk) begin
    filtered_pixel <= (dist5 <= thresh5) ? center5 : med5;
  end

  assign done = vld[5];

endmodule

// ----- tb/sv/hampel_outlier_3x3_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for hampel_outlier_3x3: directed table, then random windows
// depends on hof_pkg and the hampel_outlier_3x3 rtl

module hampel_outlier_3x3_test;
  import hof_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 10;   // six-stage pipe plus margin
  localparam int RANDOM_CHUNKS = 8;
  localparam int CHUNK_WORDS = 50;

  // one directed row: scale to run under, window, center, optional typed answer
  typedef struct packed {
    logic [7:0]      scale;
    logic [0:8][7:0] win;
    logic [7:0]      center;
    logic            typed;
    logic [7:0]      filtered;
  } window_row_t;

  localparam int DIRECTED_ROWS = 21;

  // clustered window 34/50/66 per row: median 50, mad 16
  window_row_t directed_rows [DIRECTED_ROWS] = '{
    // flat windows, zero mad
    '{8'd72, {9{8'd0}}, 8'd0, 1'b1, 8'd0},
    '{8'd72, {9{8'd255}}, 8'd255, 1'b1, 8'd255},
    '{8'd72, {9{8'd255}}, 8'd0, 1'b1, 8'd255},
    '{8'd72, {9{8'd0}}, 8'd255, 1'b1, 8'd0},
    '{8'd72, {9{8'd100}}, 8'd101, 1'b1, 8'd100},
    // center on the median always passes; then spread windows with far centers
    '{8'd72, {8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90},
      8'd50, 1'b1, 8'd50},
    '{8'd72, {8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90},
      8'd255, 1'b0, 8'd0},
    '{8'd72, {8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0},
      8'd128, 1'b0, 8'd0},
    '{8'd72, {8'd3, 8'd200, 8'd17, 8'd250, 8'd1, 8'd99, 8'd128, 8'd64, 8'd7},
      8'd0, 1'b0, 8'd0},
    // threshold edge at default scale: distance 72 passes, 73 does not
    '{8'd72, {3{8'd34, 8'd50, 8'd66}}, 8'd122, 1'b0, 8'd0},
    '{8'd72, {3{8'd34, 8'd50, 8'd66}}, 8'd123, 1'b0, 8'd0},
    // zero scale: only the median itself passes
    '{8'd0, {3{8'd34, 8'd50, 8'd66}}, 8'd50, 1'b1, 8'd50},
    '{8'd0, {3{8'd34, 8'd50, 8'd66}}, 8'd51, 1'b1, 8'd50},
    '{8'd0, {3{8'd34, 8'd50, 8'd66}}, 8'd49, 1'b1, 8'd50},
    // widest scale
    '{8'd255, {3{8'd34, 8'd50, 8'd66}}, 8'd255, 1'b0, 8'd0},
    '{8'd255, {3{8'd34, 8'd50, 8'd66}}, 8'd0, 1'b0, 8'd0},
    '{8'd255, {9{8'd0}}, 8'd255, 1'b1, 8'd0},
    '{8'd255, {8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255},
      8'd0, 1'b0, 8'd0},
    // unity scale: distance equal to mad is the edge; last row at default scale
    '{8'd16, {3{8'd34, 8'd50, 8'd66}}, 8'd66, 1'b0, 8'd0},
    '{8'd16, {3{8'd34, 8'd50, 8'd66}}, 8'd67, 1'b0, 8'd0},
    '{8'd72, {8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128, 8'd127},
      8'd254, 1'b0, 8'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [0:8][7:0]        win_drive = '0;
  logic [7:0]             center_drive = 8'd0;
  logic                   done;
  logic [7:0]             filtered_pixel;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [SCALE_WIDTH-1:0] cfg_wdata = '0;

  // typed answer that rides along with the word being driven
  logic                   typed_flag = 1'b0;
  logic [7:0]             typed_value = 8'd0;

  logic [7:0]             filtered_q [$];
  logic [7:0]             scale_now = SCALE_RESET;
  logic [7:0]             want;
  int                     sender_idle_pct = 0;
  int                     fail_count = 0;
  int                     cycles = 0;

  always #5 clk = ~clk;

  hampel_outlier_3x3 #(
    .PIXEL_WIDTH(8)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .pixel_r0c0    (win_drive[0]),
    .pixel_r0c1    (win_drive[1]),
    .pixel_r0c2    (win_drive[2]),
    .pixel_r1c0    (win_drive[3]),
    .pixel_r1c1    (win_drive[4]),
    .pixel_r1c2    (win_drive[5]),
    .pixel_r2c0    (win_drive[6]),
    .pixel_r2c1    (win_drive[7]),
    .pixel_r2c2    (win_drive[8]),
    .center_pixel  (center_drive),
    .done          (done),
    .filtered_pixel(filtered_pixel),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_wdata     (cfg_wdata)
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] mid_of3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] lo_ab;
    logic [7:0] hi_ab;
    logic [7:0] lo_hc;
    lo_ab = (a < b) ? a : b;
    hi_ab = (a > b) ? a : b;
    lo_hc = (hi_ab < c) ? hi_ab : c;
    return (lo_ab > lo_hc) ? lo_ab : lo_hc;
  endfunction

  // row sort then median of (min of maxima, median of middles, max of minima)
  function automatic logic [7:0] window_median(logic [0:8][7:0] w);
    logic [7:0] row_hi [3];
    logic [7:0] row_mid [3];
    logic [7:0] row_lo [3];
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] min_hi;
    logic [7:0] max_lo;
    for (int r = 0; r < 3; r++) begin
      a = w[r*3];
      b = w[r*3+1];
      c = w[r*3+2];
      row_hi[r] = (a > b) ? ((a > c) ? a : c) : ((b > c) ? b : c);
      row_lo[r] = (a < b) ? ((a < c) ? a : c) : ((b < c) ? b : c);
      row_mid[r] = mid_of3(a, b, c);
    end
    min_hi = row_hi[0];
    max_lo = row_lo[0];
    for (int r = 1; r < 3; r++) begin
      if (row_hi[r] < min_hi) min_hi = row_hi[r];
      if (row_lo[r] > max_lo) max_lo = row_lo[r];
    end
    return mid_of3(min_hi, mid_of3(row_mid[0], row_mid[1], row_mid[2]), max_lo);
  endfunction

  function automatic logic [7:0] abs_gap(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // keep the center if 16*|center - median| <= scale * mad, else the median
  function automatic logic [7:0] hampel_pick(logic [0:8][7:0] w, logic [7:0] center,
                                             logic [7:0] scale);
    logic [0:8][7:0] gaps;
    logic [7:0]      med;
    logic [7:0]      mad;
    int unsigned     lhs;
    int unsigned     rhs;
    med = window_median(w);
    for (int i = 0; i < 9; i++) gaps[i] = abs_gap(w[i], med);
    mad = window_median(gaps);
    lhs = abs_gap(center, med) << Q_SHIFT;
    rhs = scale * mad;
    return (lhs <= rhs) ? center : med;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
    $display("%0t ns  %s: got %0d want %0d", $time, what, got, exp_val);
    fail_count++;
  endtask

  // results popped first, then the word taken at this edge is predicted
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (done) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("filtered_pixel with no word pending", filtered_pixel, 8'd0);
        end else begin
          want = filtered_q.pop_front();
          if (filtered_pixel !== want)
            report_mismatch("filtered_pixel", filtered_pixel, want);
        end
      end
      if (start && !busy)
        filtered_q.push_back(typed_flag ? typed_value :
                             hampel_pick(win_drive, center_drive, scale_now));
      if (cfg_valid && cfg_ready) scale_now = cfg_wdata;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles == LIMIT_CYCLES) begin
      $display("hampel_outlier_3x3: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // drive one word at the falling edge, hold it until an edge with busy low
  task automatic send_window(logic [0:8][7:0] w, logic [7:0] center, logic typed,
                             logic [7:0] filtered);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    win_drive <= w;
    center_drive <= center;
    typed_flag <= typed;
    typed_value <= filtered;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // every word yields a result, so an empty queue means the pipe is empty
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [7:0] value);
    drain_pipe();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] clamp_pixel(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // clustered windows in four of the ten shapes so both keep and replace happen often
  task automatic random_window(output logic [0:8][7:0] w, output logic [7:0] center);
    int shape;
    int base;
    int spread;
    shape = $urandom_range(9);
    base = $urandom_range(255);
    spread = $urandom_range(15);
    for (int i = 0; i < 9; i++) begin
      case (shape)
        0, 1, 2, 3: begin
          w[i] = clamp_pixel(base + $urandom_range(2*spread) - spread);
        end
        7: begin
          // flat with the odd stray pixel
          w[i] = ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : 8'(base);
        end
        8: begin
          w[i] = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        default: begin
          w[i] = 8'($urandom_range(255));
        end
      endcase
    end
    case (shape)
      0, 1, 2, 3: center = clamp_pixel(base + $urandom_range(128) - 64);
      8:          center = $urandom_range(2) == 0 ? 8'($urandom_range(255)) :
                           ($urandom_range(1) ? 8'd255 : 8'd0);
      9:          center = w[$urandom_range(8)];
      default:    center = 8'($urandom_range(255));
    endcase
  endtask

  logic [0:8][7:0] rand_win;
  logic [7:0]      rand_center;
  logic [7:0]      chunk_scale;

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, scale changes only between words with the pipe empty
    sender_idle_pct = 37;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].scale != scale_now) write_scale(directed_rows[i].scale);
      send_window(directed_rows[i].win, directed_rows[i].center,
                  directed_rows[i].typed, directed_rows[i].filtered);
    end

    // random chunks: idle 37% then 74% then none, scale per chunk
    for (int k = 0; k < RANDOM_CHUNKS; k++) begin
      case (k)
        0:       chunk_scale = 8'd255;
        1:       chunk_scale = 8'd1;
        3:       chunk_scale = 8'd16;
        4:       chunk_scale = 8'd0;
        6:       chunk_scale = SCALE_RESET;
        default: chunk_scale = 8'($urandom_range(255));
      endcase
      write_scale(chunk_scale);
      sender_idle_pct = (k < 3) ? 37 : (k < 6) ? 74 : 0;
      for (int n = 0; n < CHUNK_WORDS; n++) begin
        random_window(rand_win, rand_center);
        send_window(rand_win, rand_center, 1'b0, 8'd0);
      end
    end

    drain_pipe();
    if (filtered_q.size() != 0)
      report_mismatch("words left without a result", 8'd0, 8'd0);

    if (fail_count == 0) begin
      $display("hampel_outlier_3x3: match");
    end else begin
      $display("hampel_outlier_3x3: mismatch");
    end
    $finish;
  end

endmodule
